// ===== rtl/core/rgbhsv_pkg.sv =====
// Package for the RGB to HSV converter: widths, divider sizing, sector codes
// and the record types passed between the front end, the queue and the back end.
// Depends on nothing.
package rgbhsv_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned HUE_FRAC    = 6;
  localparam int unsigned HUE_W       = 15;
  localparam int unsigned HUE_SIXTY   = 60 << HUE_FRAC;
  localparam int unsigned HUE_FULL    = 360 << HUE_FRAC;
  localparam int unsigned HUE_Q_W     = $clog2(HUE_SIXTY + 1);
  localparam int unsigned DIV_STEPS   = (HUE_Q_W > CHAN_W) ? HUE_Q_W : CHAN_W;
  localparam int unsigned REM_W       = CHAN_W + DIV_STEPS;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    chan_t   mx;
    chan_t   delta;
    chan_t   diff_mag;
    logic    diff_neg;
    sector_e sector;
    logic    gray;
  } cls_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem_hue;
    logic [REM_W-1:0]     rem_sat;
    chan_t                div_hue;
    chan_t                div_sat;
    logic [DIV_STEPS-1:0] q_hue;
    logic [DIV_STEPS-1:0] q_sat;
    chan_t                mx;
    logic                 diff_neg;
    sector_e              sector;
    logic                 gray;
  } div_t;

endpackage

// ===== rtl/core/rgbhsv_if.sv =====
// Stream interfaces of the RGB to HSV converter: pixel in, HSV result out.
// Depends on rgbhsv_pkg.
interface rgbhsv_pix_if;
  logic                  valid;
  logic                  ready;
  rgbhsv_pkg::chan_t     red;
  rgbhsv_pkg::chan_t     green;
  rgbhsv_pkg::chan_t     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsv_pkg::HUE_W-1:0] hue;
  rgbhsv_pkg::chan_t            saturation;
  rgbhsv_pkg::chan_t            brightness;
  logic                         achromatic;

  modport source (output valid, hue, saturation, brightness, achromatic, input ready);
  modport sink   (input valid, hue, saturation, brightness, achromatic, output ready);
endinterface

// ===== rtl/core/rgbhsv_front.sv =====
// Front end: accept a pixel beat, find max, min and delta, pick the hue sector
// and the signed channel difference, and register the classified record.
// Depends on rgbhsv_pkg and rgbhsv_pix_if.
module rgbhsv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  rgbhsv_pix_if.sink         pix_i,
  output rgbhsv_pkg::cls_t   cls_o,
  output logic               cls_valid_o,
  input  logic               cls_ready_i
);

  rgbhsv_pkg::cls_t cls_d, cls_q;
  logic             valid_q;
  rgbhsv_pkg::chan_t mx, mn;
  logic [rgbhsv_pkg::CHAN_W:0] diff;

  assign pix_i.ready = !valid_q || cls_ready_i;
  assign cls_o       = cls_q;
  assign cls_valid_o = valid_q;

  always_comb begin
    mx = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    mx = (mx > pix_i.blue) ? mx : pix_i.blue;
    mn = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    mn = (mn < pix_i.blue) ? mn : pix_i.blue;
    if (pix_i.red >= mx) begin
      cls_d.sector = rgbhsv_pkg::SECT_RED;
      diff = {1'b0, pix_i.green} - {1'b0, pix_i.blue};
    end else if (pix_i.green >= mx) begin
      cls_d.sector = rgbhsv_pkg::SECT_GREEN;
      diff = {1'b0, pix_i.blue} - {1'b0, pix_i.red};
    end else begin
      cls_d.sector = rgbhsv_pkg::SECT_BLUE;
      diff = {1'b0, pix_i.red} - {1'b0, pix_i.green};
    end
    cls_d.mx       = mx;
    cls_d.delta    = mx - mn;
    cls_d.gray     = (mx == mn);
    cls_d.diff_neg = diff[rgbhsv_pkg::CHAN_W];
    cls_d.diff_mag = diff[rgbhsv_pkg::CHAN_W] ? rgbhsv_pkg::CHAN_W'(-diff)
                                              : diff[rgbhsv_pkg::CHAN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ===== rtl/core/rgbhsv_queue.sv =====
// Short FIFO between front end and back end so each side stalls on its own.
// Depends on rgbhsv_pkg.
module rgbhsv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgbhsv_pkg::cls_t   push_data_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output rgbhsv_pkg::cls_t   pop_data_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);

  rgbhsv_pkg::cls_t                  mem_q [rgbhsv_pkg::QUEUE_DEPTH];
  logic [rgbhsv_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rgbhsv_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                              push, pop;

  assign push_ready_o = (count_q != rgbhsv_pkg::QCNT_W'(rgbhsv_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rgbhsv_pkg::QCNT_W'(rgbhsv_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != rgbhsv_pkg::QCNT_W'(rgbhsv_pkg::QUEUE_DEPTH) |->
      rgbhsv_pkg::QPTR_W'(wr_ptr_q - rd_ptr_q) == rgbhsv_pkg::QPTR_W'(count_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/rgbhsv_back.sv =====
// Back end: scale the operands, run both divisions one quotient bit per stage,
// then add the sector base, wrap negative hue and register the result beat.
// Depends on rgbhsv_pkg and rgbhsv_hsv_if.
module rgbhsv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgbhsv_pkg::cls_t   cls_i,
  input  logic               cls_valid_i,
  output logic               cls_ready_o,
  rgbhsv_hsv_if.source       hsv_o
);

  localparam int unsigned NST = rgbhsv_pkg::DIV_STEPS;
  localparam int unsigned HW  = rgbhsv_pkg::HUE_W;

  function automatic rgbhsv_pkg::div_t div_step(rgbhsv_pkg::div_t s, int unsigned bit_i);
    rgbhsv_pkg::div_t              n;
    logic [rgbhsv_pkg::REM_W-1:0]  dh;
    logic [rgbhsv_pkg::REM_W-1:0]  ds;
    n  = s;
    dh = rgbhsv_pkg::REM_W'(s.div_hue) << bit_i;
    ds = rgbhsv_pkg::REM_W'(s.div_sat) << bit_i;
    if (s.rem_hue >= dh) begin
      n.rem_hue      = s.rem_hue - dh;
      n.q_hue[bit_i] = 1'b1;
    end
    if (s.rem_sat >= ds) begin
      n.rem_sat      = s.rem_sat - ds;
      n.q_sat[bit_i] = 1'b1;
    end
    return n;
  endfunction

  logic                     en;
  logic [NST:0]             vld_q;
  rgbhsv_pkg::div_t         st_q [NST+1];
  rgbhsv_pkg::div_t         load;
  logic [HW:0]              base, quo, hue_full;
  logic [HW-1:0]            hue_d;

  assign en          = !hsv_o.valid || hsv_o.ready;
  assign cls_ready_o = en;

  always_comb begin
    load          = '0;
    load.rem_hue  = rgbhsv_pkg::REM_W'(rgbhsv_pkg::HUE_SIXTY * cls_i.diff_mag);
    load.rem_sat  = (rgbhsv_pkg::REM_W'(cls_i.delta) << rgbhsv_pkg::CHAN_W)
                    - rgbhsv_pkg::REM_W'(cls_i.delta);
    load.div_hue  = cls_i.delta;
    load.div_sat  = cls_i.mx;
    load.mx       = cls_i.mx;
    load.diff_neg = cls_i.diff_neg;
    load.sector   = cls_i.sector;
    load.gray     = cls_i.gray;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-1:0], cls_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= load;
    end
  end

  for (genvar k = 1; k <= NST; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= div_step(st_q[k-1], NST - k);
      end
    end
  end

  always_comb begin
    unique case (st_q[NST].sector)
      rgbhsv_pkg::SECT_RED:   base = '0;
      rgbhsv_pkg::SECT_GREEN: base = (HW+1)'(2 * rgbhsv_pkg::HUE_SIXTY);
      rgbhsv_pkg::SECT_BLUE:  base = (HW+1)'(4 * rgbhsv_pkg::HUE_SIXTY);
      default:                base = '0;
    endcase
    quo      = (HW+1)'(st_q[NST].q_hue);
    hue_full = (HW+1)'(rgbhsv_pkg::HUE_FULL);
    if (!st_q[NST].diff_neg) begin
      hue_d = HW'(base + quo);
    end else if (base < quo) begin
      hue_d = HW'(hue_full + base - quo);
    end else begin
      hue_d = HW'(base - quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_o.valid <= 1'b0;
    end else if (en) begin
      hsv_o.valid <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hsv_o.hue        <= st_q[NST].gray ? '0 : hue_d;
      hsv_o.saturation <= st_q[NST].gray ? '0
                          : st_q[NST].q_sat[rgbhsv_pkg::CHAN_W-1:0];
      hsv_o.brightness <= st_q[NST].mx;
      hsv_o.achromatic <= st_q[NST].gray;
    end
  end

`ifndef SYNTH
  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.achromatic |-> hsv_o.hue == '0 && hsv_o.saturation == '0)
    else $error("gray beat with nonzero hue or saturation");
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> hsv_o.hue < HW'(rgbhsv_pkg::HUE_FULL))
    else $error("hue out of range");
  a_color_bright: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && !hsv_o.achromatic |-> hsv_o.brightness != '0)
    else $error("colored beat with zero brightness");
`endif

endmodule

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: front end, queue, divider back end.
// Depends on rgbhsv_pkg, rgbhsv_if, rgbhsv_front, rgbhsv_queue, rgbhsv_back.
//
//   channel  dir  fields                                      handshake
//   pix_i    in   red, green, blue (8b each)                  valid/ready
//   hsv_o    out  hue (15b), saturation, brightness, achromatic  valid/ready
//
// One pixel per clock sustained while the output accepts result beats.
// The path is 16 registers: front, queue slot, operand load, 12 divider
// stages (one quotient bit of hue and saturation each), output.
// Reset clears the valid bits and the queue pointers; payload is not reset.
// An output stall freezes the back end; the 4-beat queue lets the front end
// keep accepting pixels until it fills.
module rgb_to_hsv_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgbhsv_pix_if.sink    pix_i,
  rgbhsv_hsv_if.source  hsv_o
);

  rgbhsv_pkg::cls_t front_cls, queue_cls;
  logic             front_valid, front_ready;
  logic             queue_valid, back_ready;

  rgbhsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  rgbhsv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cls),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_cls),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready)
  );

  rgbhsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (queue_cls),
    .cls_valid_i (queue_valid),
    .cls_ready_o (back_ready),
    .hsv_o       (hsv_o)
  );

endmodule
